// ===== hdl/gpd_pkg.sv =====
package gpd_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_WIDTH   = 3'd0,
		CFG_HEIGHT  = 3'd1,
		CFG_START_X = 3'd2,
		CFG_START_Y = 3'd3,
		CFG_GOAL_X  = 3'd4,
		CFG_GOAL_Y  = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CELL,
		ST_CLEAR,
		ST_CHK_START,
		ST_CHK_GOAL,
		ST_LOOP,
		ST_PROBE,
		ST_POP,
		ST_DONE
	} state_t;

	localparam int unsigned LEN_MAX = 4095;

	typedef struct packed {
		logic       found;
		logic       blocked;
		logic       status;
		logic [11:0] length;
	} result_t;

endpackage

// ===== hdl/grid_path_depth_first_search.sv =====
// Grid maze depth-first search. A cell write or read is accepted in the idle
// state, then passes the cell state, which uses the occupancy read, and the
// done state, which offers the result. A search with start and goal on the
// grid first clears the visited map, one entry a cycle, all 2^(XW+YW) entries
// (4096 for a 64 by 64 grid), and then checks the start and goal cells. It
// then walks the grid through the occupancy, visited and stack memories: the
// loop state skips a direction that leaves the grid, a neighbour is probed in
// the loop and probe states and a backtrack step passes the loop and pop
// states. Every cell is entered at most once, so a walk is bounded by about
// four probes and one backtrack per cell. Reset needs no clearing pass.
// in_stall stays high while an item is in progress. A finished result moves
// into an output register and waits there until taken. A further result waits
// in the done state, with in_stall high, until that register frees.
module grid_path_depth_first_search
	import gpd_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 64,
	parameter int unsigned MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [5:0]  cell_x,
	input  logic [5:0]  cell_y,
	input  logic        blocked_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        cell_blocked,
	output logic        path_found,
	output logic [11:0] path_length,
	output logic        status
);

	localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned XW = $clog2(MAX_WIDTH);
	localparam int unsigned YW = $clog2(MAX_HEIGHT);
	localparam int unsigned AW = XW + YW;
	localparam int unsigned DW = AW + 1;
	localparam int unsigned MEM_DEPTH = 1 << AW;

	logic [6:0] width_q, height_q;
	logic [5:0] sx_q, sy_q, gx_q, gy_q;
	logic [8:0] used_w, used_h;

	state_t state_q, state_d;
	logic [5:0] cx_in_q, cy_in_q;
	logic bv_in_q;
	logic [1:0] cmd_q;
	logic [XW-1:0] cur_x_q, nx_q;
	logic [YW-1:0] cur_y_q, ny_q;
	logic [DW-1:0] depth_q;
	logic [2:0] dir_q;
	logic [AW-1:0] clr_q;
	result_t res_q;
	result_t out_res_q;
	logic out_valid_q;

	// memory ports
	logic occ_we, vis_we, stk_we;
	logic [AW-1:0] occ_wa, occ_ra, vis_wa, vis_ra, stk_wa, stk_ra;
	logic occ_wd, occ_rd, vis_wd, vis_rd;
	logic [2:0] stk_wd, stk_rd;

	gpd_mem #(.DEPTH(MEM_DEPTH), .AW(AW), .DW(1)) u_occ (
		.clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd),
		.raddr(occ_ra), .rdata(occ_rd));
	gpd_mem #(.DEPTH(MEM_DEPTH), .AW(AW), .DW(1)) u_vis (
		.clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
		.raddr(vis_ra), .rdata(vis_rd));
	gpd_mem #(.DEPTH(MEM_DEPTH), .AW(AW), .DW(3)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.raddr(stk_ra), .rdata(stk_rd));

	always_comb begin
		used_w = (width_q > 7'(MAX_WIDTH > 127 ? 127 : MAX_WIDTH))
			? 9'(MAX_WIDTH) : 9'(width_q);
		used_h = (height_q > 7'(MAX_HEIGHT > 127 ? 127 : MAX_HEIGHT))
			? 9'(MAX_HEIGHT) : 9'(height_q);
	end

	function automatic logic [AW-1:0] addr_of(input logic [8:0] x, input logic [8:0] y);
		addr_of = {y[YW-1:0], x[XW-1:0]};
	endfunction

	// neighbour of the current cell in direction dir_q, or opposite the popped direction in the pop state
	logic [8:0] nbx, nby;
	logic nb_ok;
	logic [1:0] nb_dir;
	logic [2:0] pop_dir;
	always_comb begin
		nb_dir = (state_q == ST_POP) ? pop_dir[1:0] + 2'd2 : dir_q[1:0];
		nbx = 9'(cur_x_q);
		nby = 9'(cur_y_q);
		nb_ok = 1'b1;
		case (nb_dir)
			2'd0: nby = 9'(cur_y_q) + 9'd1;
			2'd1: nbx = 9'(cur_x_q) + 9'd1;
			2'd2: begin
				if (cur_y_q == '0) nb_ok = 1'b0;
				nby = 9'(cur_y_q) - 9'd1;
			end
			default: begin
				if (cur_x_q == '0) nb_ok = 1'b0;
				nbx = 9'(cur_x_q) - 9'd1;
			end
		endcase
		nb_ok = nb_ok && nbx < used_w && nby < used_h;
	end
	assign pop_dir = stk_rd;

	logic cell_in, start_in, goal_in;
	assign cell_in  = 9'(cx_in_q) < used_w && 9'(cy_in_q) < used_h;
	assign start_in = 9'(sx_q) < used_w && 9'(sy_q) < used_h;
	assign goal_in  = 9'(gx_q) < used_w && 9'(gy_q) < used_h;

	logic [DW-1:0] depth_m1;
	assign depth_m1 = depth_q - DW'(1);
	logic is_goal_nb;
	assign is_goal_nb = nx_q == gx_q[XW-1:0] && ny_q == gy_q[YW-1:0]
		&& 9'(gx_q) < 9'(MAX_WIDTH) && 9'(gy_q) < 9'(MAX_HEIGHT);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (in_valid && !in_stall) begin
					if (cmd == CMD_SEARCH) state_d = ST_CLEAR;
					else state_d = ST_CELL;
				end
			ST_CELL: state_d = ST_DONE;
			ST_CLEAR:
				if (!start_in || !goal_in) state_d = ST_DONE;
				else if (clr_q == AW'(MEM_DEPTH - 1)) state_d = ST_CHK_START;
			ST_CHK_START: state_d = ST_CHK_GOAL;
			ST_CHK_GOAL:
				if (occ_rd || start_blk_q) state_d = ST_DONE;
				else state_d = ST_LOOP;
			ST_LOOP: begin
				if (res_q.found || res_q.blocked) state_d = ST_DONE;
				else if (dir_q[2]) state_d = (depth_q == '0) ? ST_DONE : ST_POP;
				else if (nb_ok) state_d = ST_PROBE;
			end
			ST_PROBE: state_d = ST_LOOP;
			ST_POP: state_d = ST_LOOP;
			ST_DONE:
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		occ_we = 1'b0; occ_wa = addr_of(9'(cx_in_q), 9'(cy_in_q)); occ_wd = bv_in_q;
		occ_ra = addr_of(9'(cell_x), 9'(cell_y));
		vis_we = 1'b0; vis_wa = clr_q; vis_wd = 1'b0;
		vis_ra = addr_of(nbx, nby);
		stk_we = 1'b0; stk_wa = depth_q[AW-1:0]; stk_wd = dir_q;
		stk_ra = depth_m1[AW-1:0];
		case (state_q)
			ST_CELL: occ_we = (cmd_q == CMD_WRITE) && cell_in;
			ST_CLEAR: begin
				vis_we = 1'b1;
				occ_ra = addr_of(9'(sx_q), 9'(sy_q));
			end
			ST_CHK_START: occ_ra = addr_of(9'(gx_q), 9'(gy_q));
			ST_CHK_GOAL: begin
				vis_we = 1'b1; vis_wd = 1'b1;
				vis_wa = addr_of(9'(sx_q), 9'(sy_q));
			end
			ST_LOOP: occ_ra = addr_of(nbx, nby);
			ST_PROBE: begin
				if (!occ_rd && !vis_rd && 32'(depth_q) + 1 < CELLS) begin
					vis_we = 1'b1; vis_wd = 1'b1;
					vis_wa = addr_of(9'(nx_q), 9'(ny_q));
					stk_we = 1'b1; stk_wd = dir_q;
				end
			end
			default: ;
		endcase
	end

	// occupancy read for the start check is held in a register for the goal check
	logic start_blk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			width_q <= 7'd64; height_q <= 7'd64;
			sx_q <= '0; sy_q <= '0; gx_q <= 6'd63; gy_q <= 6'd63;
			out_valid_q <= 1'b0;
			cur_x_q <= '0; cur_y_q <= '0; depth_q <= '0;
			dir_q <= '0; clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:   width_q  <= cfg_data;
					CFG_HEIGHT:  height_q <= cfg_data;
					CFG_START_X: sx_q <= cfg_data[5:0];
					CFG_START_Y: sy_q <= cfg_data[5:0];
					CFG_GOAL_X:  gx_q <= cfg_data[5:0];
					CFG_GOAL_Y:  gy_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (state_q == ST_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: clr_q <= '0;
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_CHK_GOAL: begin
					cur_x_q <= sx_q[XW-1:0]; cur_y_q <= sy_q[YW-1:0];
					depth_q <= '0; dir_q <= '0;
				end
				ST_LOOP:
					if (!res_q.found && !res_q.blocked) begin
						if (dir_q[2]) begin
							if (depth_q != '0) depth_q <= depth_m1;
						end else if (nb_ok) begin
							nx_q <= nbx[XW-1:0]; ny_q <= nby[YW-1:0];
						end else
							dir_q <= dir_q + 3'd1;
					end
				ST_PROBE:
					if (!occ_rd && !vis_rd && 32'(depth_q) + 1 < CELLS) begin
						cur_x_q <= nx_q; cur_y_q <= ny_q;
						depth_q <= depth_q + DW'(1);
						dir_q <= '0;
					end else
						dir_q <= dir_q + 3'd1;
				ST_POP: begin
					if (nb_ok) begin
						cur_x_q <= nbx[XW-1:0]; cur_y_q <= nby[YW-1:0];
					end
					dir_q <= pop_dir + 3'd1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !in_stall) begin
			cmd_q <= cmd; cx_in_q <= cell_x; cy_in_q <= cell_y; bv_in_q <= blocked_value;
			res_q <= '0;
		end
		if (state_q == ST_DONE && (!out_valid_q || !out_stall))
			out_res_q <= res_q;
		case (state_q)
			ST_CELL: begin
				res_q.status <= (cmd_q == CMD_WRITE || cmd_q == CMD_READ) && !cell_in;
				res_q.blocked <= (cmd_q == CMD_READ) && cell_in && occ_rd;
			end
			ST_CLEAR: res_q.status <= !start_in || !goal_in;
			ST_CHK_START: start_blk_q <= occ_rd;
			ST_CHK_GOAL: begin
				if (!occ_rd && !start_blk_q && sx_q == gx_q && sy_q == gy_q)
					res_q.found <= 1'b1;
				else if (start_blk_q) res_q.status <= 1'b0;
			end
			ST_PROBE:
				if (!occ_rd && !vis_rd && 32'(depth_q) + 1 < CELLS && is_goal_nb) begin
					res_q.found <= 1'b1;
					res_q.length <= (32'(depth_q) + 1 > LEN_MAX)
						? 12'(LEN_MAX) : 12'(depth_q + DW'(1));
				end
			default: ;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign cell_blocked = out_res_q.blocked && !out_res_q.found;
	assign path_found = out_res_q.found;
	assign path_length = out_res_q.found ? out_res_q.length : 12'd0;
	assign status = out_res_q.status;

`ifndef SYNTH
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && state_d == ST_IDLE) |=> out_valid)
		else $error("result not raised");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("accepting while busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped");
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(path_length) && $stable(path_found)
		&& $stable(cell_blocked) && $stable(status)))
		else $error("stalled item changed");
`endif

endmodule

// ===== hdl/gpd_mem.sv =====
// parameterised-width synchronous memory, one write and one read port, registered read
module gpd_mem
	import gpd_pkg::*;
#(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12,
	parameter int unsigned DW    = 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import gpd_pkg::*;

	localparam int unsigned GRID_DIM  = 64;
	localparam int unsigned CELLS     = GRID_DIM * GRID_DIM;
	localparam int unsigned FILL_DIM  = 8;
	localparam int unsigned RAND_ITEMS = 330;
	localparam int unsigned EXP_DEPTH = 64;
	localparam int unsigned MAX_STEPS = 40;
	localparam longint unsigned CYCLE_LIMIT = 4000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [6:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [5:0]  cell_x;
	logic [5:0]  cell_y;
	logic        blocked_value;
	logic        out_valid;
	logic        out_stall;
	logic        cell_blocked;
	logic        path_found;
	logic [11:0] path_length;
	logic        status;

	grid_path_depth_first_search dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .cell_x(cell_x), .cell_y(cell_y), .blocked_value(blocked_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.cell_blocked(cell_blocked), .path_found(path_found),
		.path_length(path_length), .status(status)
	);

	// grid model
	logic [6:0] grid_w, grid_h;
	logic [5:0] start_col, start_row, goal_col, goal_row;
	bit occ_map [CELLS];
	bit seen_map [CELLS];
	int unsigned dir_stack [CELLS];

	// expected results in order of acceptance
	result_t exp_fifo [EXP_DEPTH];
	int unsigned exp_wr = 0;
	int unsigned exp_rd = 0;
	int unsigned errors;
	longint unsigned cycles = 0;
	int unsigned n_writes, n_reads, n_searches, n_found, n_outside, n_results;
	bit hold_req, hold_done;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int unsigned used_w();
		return (grid_w > GRID_DIM) ? GRID_DIM : grid_w;
	endfunction

	function automatic int unsigned used_h();
		return (grid_h > GRID_DIM) ? GRID_DIM : grid_h;
	endfunction

	function automatic bit on_grid(int unsigned x, int unsigned y);
		return x < used_w() && y < used_h();
	endfunction

	function automatic int unsigned cell_addr(int unsigned x, int unsigned y);
		return (y * GRID_DIM + x) % CELLS;
	endfunction

	// direction 0 north, 1 east, 2 south, 3 west
	function automatic bit move_ok(int unsigned x, int unsigned y, int unsigned d,
			output int unsigned nx, output int unsigned ny);
		nx = x;
		ny = y;
		case (d)
			0: ny = y + 1;
			1: nx = x + 1;
			2: begin
				if (y == 0) return 0;
				ny = y - 1;
			end
			default: begin
				if (x == 0) return 0;
				nx = x - 1;
			end
		endcase
		return on_grid(nx, ny);
	endfunction

	function automatic bit walk_maze(output int unsigned len);
		int unsigned cx, cy, depth, lvl, d, nx, ny, px, py;
		len = 0;
		foreach (seen_map[i]) seen_map[i] = 0;
		if (occ_map[cell_addr(start_col, start_row)] || occ_map[cell_addr(goal_col, goal_row)])
			return 0;
		cx = start_col;
		cy = start_row;
		depth = 0;
		seen_map[cell_addr(cx, cy)] = 1;
		if (cx == goal_col && cy == goal_row)
			return 1;
		dir_stack[0] = 0;
		forever begin
			lvl = depth % CELLS;
			d = dir_stack[lvl];
			if (d >= 4) begin
				if (depth == 0)
					return 0;
				depth--;
				lvl = depth % CELLS;
				if (move_ok(cx, cy, (dir_stack[lvl] + 2) & 3, px, py)) begin
					cx = px;
					cy = py;
				end
				dir_stack[lvl]++;
			end else if (move_ok(cx, cy, d, nx, ny) && !occ_map[cell_addr(nx, ny)] &&
					!seen_map[cell_addr(nx, ny)] && depth + 1 < CELLS) begin
				seen_map[cell_addr(nx, ny)] = 1;
				cx = nx;
				cy = ny;
				depth++;
				dir_stack[depth % CELLS] = 0;
				if (nx == goal_col && ny == goal_row) begin
					len = depth;
					return 1;
				end
			end else begin
				dir_stack[lvl] = d + 1;
			end
		end
	endfunction

	function automatic result_t grid_answer(cmd_t c, int unsigned x, int unsigned y, bit bv);
		result_t r;
		int unsigned len;
		r = '0;
		if (c == CMD_WRITE || c == CMD_READ) begin
			if (!on_grid(x, y))
				r.status = 1'b1;
			else if (c == CMD_WRITE)
				occ_map[cell_addr(x, y)] = bv;
			else
				r.blocked = occ_map[cell_addr(x, y)];
		end else if (c == CMD_SEARCH) begin
			if (!on_grid(start_col, start_row) || !on_grid(goal_col, goal_row)) begin
				r.status = 1'b1;
			end else if (walk_maze(len)) begin
				r.found = 1'b1;
				r.length = 12'((len > LEN_MAX) ? LEN_MAX : len);
			end
		end
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		$display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want, got);
		errors++;
	endtask

	// result side: random stalls plus one long hold-off on request
	int unsigned stall_left;
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int unsigned r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (exp_wr == exp_rd) begin
					report_mismatch("unexpected item", 0, 1);
				end else begin
					want = exp_fifo[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (cell_blocked !== want.blocked)
						report_mismatch("cell_blocked", want.blocked, cell_blocked);
					if (path_found !== want.found)
						report_mismatch("path_found", want.found, path_found);
					if (path_length !== want.length)
						report_mismatch("path_length", want.length, path_length);
					if (status !== want.status)
						report_mismatch("status", want.status, status);
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1;
				stall_left = 400;
			end else if (stall_left == 0) begin
				r = $urandom_range(99);
				if (r < 65) stall_left = 0;
				else if (r < 95) stall_left = $urandom_range(3, 1);
				else stall_left = $urandom_range(50, 15);
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	task automatic send_item(cmd_t c, int unsigned x, int unsigned y, bit bv,
			bit typed, result_t typed_ans);
		int unsigned gap;
		result_t ans;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		cell_x        <= x[5:0];
		cell_y        <= y[5:0];
		blocked_value <= bv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ans = grid_answer(c, x, y, bv);
		exp_fifo[exp_wr % EXP_DEPTH] = typed ? typed_ans : ans;
		exp_wr++;
		case (c)
			CMD_WRITE: n_writes++;
			CMD_READ: n_reads++;
			CMD_SEARCH: begin
				n_searches++;
				if (ans.found) n_found++;
			end
			default: ;
		endcase
		if (ans.status) n_outside++;
	endtask

	task automatic wait_idle();
		int unsigned guard;
		in_valid <= 1'b0;
		guard = 0;
		while (exp_wr != exp_rd && guard < 2000000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(logic [6:0] w, logic [6:0] h, logic [6:0] sx, logic [6:0] sy,
			logic [6:0] gx, logic [6:0] gy);
		logic [6:0] vals [6];
		vals = '{w, h, sx, sy, gx, gy};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		grid_w    = w;
		grid_h    = h;
		start_col = sx[5:0];
		start_row = sy[5:0];
		goal_col  = gx[5:0];
		goal_row  = gy[5:0];
	endtask

	typedef struct {
		bit         is_cfg;
		cmd_t       c;
		int unsigned x, y;
		bit         bv;
		bit         typed;
		result_t    ans;
		logic [6:0] regs [6];
	} step_row_t;

	step_row_t steps [MAX_STEPS];
	int unsigned n_steps = 0;

	task automatic add_row(step_row_t s);
		steps[n_steps] = s;
		n_steps++;
	endtask

	function automatic step_row_t item_row(cmd_t c, int unsigned x, int unsigned y, bit bv,
			bit typed, bit found, bit blk, bit st, int unsigned len);
		step_row_t s;
		s.is_cfg = 0;
		s.c = c;
		s.x = x;
		s.y = y;
		s.bv = bv;
		s.typed = typed;
		s.ans.found = found;
		s.ans.blocked = blk;
		s.ans.status = st;
		s.ans.length = 12'(len);
		return s;
	endfunction

	function automatic step_row_t cfg_row(logic [6:0] w, logic [6:0] h, logic [6:0] sx,
			logic [6:0] sy, logic [6:0] gx, logic [6:0] gy);
		step_row_t s;
		s.is_cfg = 1;
		s.regs = '{w, h, sx, sy, gx, gy};
		return s;
	endfunction

	initial begin
		int unsigned sent, n_items, w, h, r, xmax, ymax, x, y;
		cmd_t c;

		arst_n = 1'b0;
		errors = 0;
		hold_req = 0;
		hold_done = 0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_WRITE;
		cell_x = '0;
		cell_y = '0;
		blocked_value = 1'b0;
		grid_w = 64;
		grid_h = 64;
		start_col = 0;
		start_row = 0;
		goal_col = 63;
		goal_row = 63;
		foreach (occ_map[i]) occ_map[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the corner region that searches and reads use gets known values first
		for (int yy = 0; yy < FILL_DIM; yy++)
			for (int xx = 0; xx < FILL_DIM; xx++)
				send_item(CMD_WRITE, xx, yy, ($urandom_range(99) < 20), 0, '0);
		wait_idle();

		add_row(cfg_row(64, 64, 0, 0, 63, 63));
		add_row(item_row(CMD_WRITE, 63, 63, 0, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_WRITE, 0, 0, 1, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_READ, 0, 0, 0, 1, 0, 1, 0, 0));
		// blocked start gives no path
		add_row(item_row(CMD_SEARCH, 0, 0, 0, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_WRITE, 0, 0, 0, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_WRITE, 63, 63, 1, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_READ, 63, 63, 1, 1, 0, 1, 0, 0));
		// blocked goal gives no path
		add_row(item_row(CMD_SEARCH, 0, 0, 0, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_WRITE, 63, 63, 0, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_NONE, 63, 63, 1, 1, 0, 0, 0, 0));
		// oversize registers fall back to the full grid
		add_row(cfg_row(127, 127, 63, 0, 0, 63));
		add_row(item_row(CMD_WRITE, 0, 63, 0, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_WRITE, 63, 0, 1, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_READ, 63, 0, 0, 1, 0, 1, 0, 0));
		add_row(item_row(CMD_SEARCH, 0, 0, 0, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_READ, 63, 63, 0, 0, 0, 0, 0, 0));
		// zero size puts every position outside
		add_row(cfg_row(0, 0, 0, 0, 0, 0));
		add_row(item_row(CMD_WRITE, 0, 0, 1, 1, 0, 0, 1, 0));
		add_row(item_row(CMD_READ, 0, 0, 0, 1, 0, 0, 1, 0));
		add_row(item_row(CMD_SEARCH, 0, 0, 0, 1, 0, 0, 1, 0));
		add_row(cfg_row(1, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_WRITE, 0, 0, 0, 1, 0, 0, 0, 0));
		add_row(item_row(CMD_SEARCH, 0, 0, 0, 1, 1, 0, 0, 0));
		add_row(item_row(CMD_READ, 1, 0, 0, 1, 0, 0, 1, 0));
		add_row(cfg_row(4, 4, 0, 0, 5, 3));
		add_row(item_row(CMD_SEARCH, 0, 0, 0, 1, 0, 0, 1, 0));
		add_row(cfg_row(8, 8, 7, 7, 0, 0));
		add_row(item_row(CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0, 0));

		for (int i = 0; i < n_steps; i++) begin
			if (steps[i].is_cfg) begin
				wait_idle();
				set_config(steps[i].regs[0], steps[i].regs[1], steps[i].regs[2],
					steps[i].regs[3], steps[i].regs[4], steps[i].regs[5]);
			end else begin
				send_item(steps[i].c, steps[i].x, steps[i].y, steps[i].bv,
					steps[i].typed, steps[i].ans);
			end
		end

		// long receiver hold-off while cell items keep coming
		wait_idle();
		set_config(8, 8, 0, 0, 7, 7);
		hold_req = 1;
		for (int i = 0; i < 30; i++)
			send_item(CMD_WRITE, $urandom_range(7), $urandom_range(7),
				1'($urandom_range(1)), 0, '0);

		sent = 0;
		while (sent < RAND_ITEMS) begin
			wait_idle();
			r = $urandom_range(9);
			w = $urandom_range(FILL_DIM, 1);
			h = $urandom_range(FILL_DIM, 1);
			if (r == 0) begin
				w = 0;
			end else if (r == 1) begin
				h = 0;
			end else if (r == 2) begin
				w = FILL_DIM;
				h = FILL_DIM;
			end
			xmax = (w == 0) ? 0 : w - 1;
			ymax = (h == 0) ? 0 : h - 1;
			if ($urandom_range(9) == 0)
				set_config(7'(w), 7'(h), 7'($urandom_range(127)), 7'($urandom_range(127)),
					7'($urandom_range(127)), 7'($urandom_range(127)));
			else
				set_config(7'(w), 7'(h), {1'($urandom_range(1)), 6'(($urandom_range(9) == 0) ?
					xmax + 1 : $urandom_range(xmax))}, 7'($urandom_range(ymax)),
					{1'($urandom_range(1)), 6'($urandom_range(xmax))},
					7'(($urandom_range(9) == 0) ? ymax + 1 : $urandom_range(ymax)));
			n_items = $urandom_range(20, 8);
			for (int i = 0; i < n_items; i++) begin
				r = $urandom_range(99);
				if (r < 45) c = CMD_WRITE;
				else if (r < 70) c = CMD_READ;
				else if (r < 95) c = CMD_SEARCH;
				else c = CMD_NONE;
				if ($urandom_range(9) == 0) begin
					x = $urandom_range(63);
					y = $urandom_range(63);
				end else begin
					x = $urandom_range(xmax);
					y = $urandom_range(ymax);
				end
				send_item(c, x, y, ($urandom_range(99) < 35), 0, '0);
				sent++;
			end
		end

		wait_idle();
		$display("covered %0d writes, %0d reads, %0d searches (%0d paths found)",
			n_writes, n_reads, n_searches, n_found);
		$display("%0d items outside the grid, %0d results checked", n_outside, n_results);
		if (errors == 0 && exp_wr == exp_rd) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, exp_wr - exp_rd);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
